### hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shorthand for clocked concurrent assertions with a synchronous active-low
// reset that disables the check.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// When the antecedent holds, the consequent must hold at the same edge.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// When the antecedent holds, the consequent must hold at the next edge.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/ssg_pkg.sv
// ----------------------------------------------------------------------------
// ssg_pkg
// Shared widths, types and constants of the stable state event gate.
// ----------------------------------------------------------------------------
`default_nettype none

package ssg_pkg;

    localparam int BUFFER_DEPTH = 15;
    localparam int CNT_W        = $clog2(BUFFER_DEPTH + 1);
    localparam int ADDR_W       = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

    localparam int STATE_W = 8;
    localparam int TIME_W  = 32;
    localparam int PAY_W   = 32;
    localparam int TAG_W   = 16;
    localparam int FIELD_W = STATE_W + TIME_W + PAY_W + TAG_W;
    localparam int DATA_W  = ((FIELD_W + 7) / 8) * 8;

    localparam logic [TIME_W-1:0] WLEN_RESET = TIME_W'(60);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [TAG_W-1:0]  tag;
        logic [PAY_W-1:0]  payload;
        logic [TIME_W-1:0] ev_time;
    } t_entry;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        t_entry            data;
    } t_mem_wr;

    typedef struct packed {
        logic [STATE_W-1:0] state;
        logic [CNT_W-1:0]   count;
        t_entry             cur;
    } t_flush_cmd;

    typedef enum logic [1:0] {
        CL_CHANGE,
        CL_DROP,
        CL_HOLD,
        CL_FLUSH
    } t_class;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_FETCH,
        BK_LOAD
    } t_back_state;

endpackage

`default_nettype wire

### hdl/stable_state_event_gate.sv
// ----------------------------------------------------------------------------
// stable_state_event_gate
// Forwards events once their state code has held steady for a set window.
// ----------------------------------------------------------------------------
// An input word that changes the state, arrives before the window start, or
// falls inside the window is taken without holding off the input, and the
// next word may follow in the next cycle. A word at or past the window end
// releases the buffered events oldest first and then itself, with tlast on
// the final word. The output sequencer takes the release command from the
// queue in the cycle after acceptance. For each buffered event it reads the
// buffer and then loads the output register; for the closing event it loads
// the output register directly. A stalled output register holds each load
// back. The input is held off from the accepting edge of a releasing word
// until its last word has been loaded into the output register.
`default_nettype none

module stable_state_event_gate import ssg_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_wr_en,
    input  wire logic [TIME_W-1:0] i_cfg_wr_data,
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    // state_code [7:0], event_time [39:8], payload [71:40], source_tag [87:72]
    input  wire logic [DATA_W-1:0] s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    // out_state_code [7:0], out_time [39:8], out_payload [71:40], out_tag [87:72]
    output logic [DATA_W-1:0]      m_axis_tdata,
    output logic                   m_axis_tlast
);

    t_mem_wr    mem_wr;
    logic       push;
    t_flush_cmd push_cmd;
    logic       q_full;
    logic       q_valid;
    t_flush_cmd q_cmd;
    logic       q_pop;
    logic       flush_done;

    ssg_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_s_tvalid    (s_axis_tvalid),
        .o_s_tready    (s_axis_tready),
        .i_s_tdata     (s_axis_tdata),
        .o_mem_wr      (mem_wr),
        .o_push        (push),
        .o_push_cmd    (push_cmd),
        .i_q_full      (q_full),
        .i_flush_done  (flush_done)
    );

    ssg_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_cmd),
        .o_full      (q_full),
        .i_pop       (q_pop),
        .o_valid     (q_valid),
        .o_pop_data  (q_cmd)
    );

    ssg_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_mem_wr     (mem_wr),
        .i_q_valid    (q_valid),
        .i_q_cmd      (q_cmd),
        .o_q_pop      (q_pop),
        .o_flush_done (flush_done),
        .o_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .o_m_tdata    (m_axis_tdata),
        .o_m_tlast    (m_axis_tlast)
    );

endmodule

`default_nettype wire

### hdl/ssg_fifo.sv
// ----------------------------------------------------------------------------
// ssg_fifo
// Short queue of flush commands between the front and the back part.
// ----------------------------------------------------------------------------
`default_nettype none

module ssg_fifo import ssg_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_push,
    input  wire t_flush_cmd i_push_data,
    output logic            o_full,
    input  wire logic       i_pop,
    output logic            o_valid,
    output t_flush_cmd      o_pop_data
);

    t_flush_cmd         r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr;
    logic [QCNT_W-1:0]  r_cnt;
    logic [QPTR_W-1:0]  n_wr_ptr;
    logic [QPTR_W-1:0]  n_rd_ptr;
    logic [QCNT_W-1:0]  n_cnt;
    logic               do_push;
    logic               do_pop;

    assign o_full     = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_valid    = (r_cnt != '0);
    assign o_pop_data = r_mem[r_rd_ptr];
    assign do_push    = i_push && !o_full;
    assign do_pop     = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_cnt    = r_cnt;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

`default_nettype wire

### hdl/ssg_front.sv
// ----------------------------------------------------------------------------
// ssg_front
// Accepts input words, compares them against the held state and the window,
// writes buffered events and issues flush commands.
// ----------------------------------------------------------------------------
`default_nettype none

module ssg_front import ssg_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_wr_en,
    input  wire logic [TIME_W-1:0] i_cfg_wr_data,
    input  wire logic              i_s_tvalid,
    output logic                   o_s_tready,
    input  wire logic [DATA_W-1:0] i_s_tdata,
    output t_mem_wr                o_mem_wr,
    output logic                   o_push,
    output t_flush_cmd             o_push_cmd,
    input  wire logic              i_q_full,
    input  wire logic              i_flush_done
);

    logic [TIME_W-1:0]  r_wlen;
    logic [STATE_W-1:0] r_held;
    logic [TIME_W-1:0]  r_start;
    logic [CNT_W-1:0]   r_count;
    logic               r_busy;
    logic [STATE_W-1:0] n_held;
    logic [TIME_W-1:0]  n_start;
    logic [CNT_W-1:0]   n_count;
    logic               n_busy;

    logic [STATE_W-1:0] in_state;
    t_entry             in_entry;
    logic [TIME_W:0]    win_end;
    logic               accept;
    t_class             cls;

    assign in_state         = i_s_tdata[STATE_W-1:0];
    assign in_entry.ev_time = i_s_tdata[STATE_W +: TIME_W];
    assign in_entry.payload = i_s_tdata[STATE_W + TIME_W +: PAY_W];
    assign in_entry.tag     = i_s_tdata[STATE_W + TIME_W + PAY_W +: TAG_W];

    assign o_s_tready = !r_busy && !i_q_full;
    assign accept     = i_s_tvalid && o_s_tready;
    assign win_end    = {1'b0, r_start} + {1'b0, r_wlen};

    always_comb begin
        if (in_state != r_held) begin
            cls = CL_CHANGE;
        end else if (in_entry.ev_time < r_start) begin
            cls = CL_DROP;
        end else if (win_end > {1'b0, in_entry.ev_time}) begin
            cls = CL_HOLD;
        end else begin
            cls = CL_FLUSH;
        end
    end

    always_comb begin
        n_held          = r_held;
        n_start         = r_start;
        n_count         = r_count;
        n_busy          = r_busy;
        o_mem_wr.en     = 1'b0;
        o_mem_wr.addr   = '0;
        o_mem_wr.data   = in_entry;
        o_push          = 1'b0;
        o_push_cmd.state = r_held;
        o_push_cmd.count = r_count;
        o_push_cmd.cur   = in_entry;
        if (i_flush_done) begin
            n_busy = 1'b0;
        end
        if (accept) begin
            case (cls)
                CL_CHANGE: begin
                    n_held      = in_state;
                    n_start     = in_entry.ev_time;
                    n_count     = CNT_W'(1);
                    o_mem_wr.en = 1'b1;
                end
                CL_HOLD: begin
                    if (r_count < CNT_W'(BUFFER_DEPTH)) begin
                        o_mem_wr.en   = 1'b1;
                        o_mem_wr.addr = r_count[ADDR_W-1:0];
                        n_count       = r_count + 1'b1;
                    end
                end
                CL_FLUSH: begin
                    o_push  = 1'b1;
                    n_count = '0;
                    n_busy  = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wlen  <= WLEN_RESET;
            r_held  <= '0;
            r_start <= '0;
            r_count <= '0;
            r_busy  <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_wlen <= i_cfg_wr_data;
            end
            r_held  <= n_held;
            r_start <= n_start;
            r_count <= n_count;
            r_busy  <= n_busy;
        end
    end

endmodule

`default_nettype wire

### hdl/ssg_back.sv
// ----------------------------------------------------------------------------
// ssg_back
// Holds the event buffer and plays flush commands out through the output
// register, buffered events first and the closing event last.
// ----------------------------------------------------------------------------
`default_nettype none

module ssg_back import ssg_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_mem_wr           i_mem_wr,
    input  wire logic              i_q_valid,
    input  wire t_flush_cmd        i_q_cmd,
    output logic                   o_q_pop,
    output logic                   o_flush_done,
    output logic                   o_m_tvalid,
    input  wire logic              i_m_tready,
    output logic [DATA_W-1:0]      o_m_tdata,
    output logic                   o_m_tlast
);

    t_entry             r_mem [BUFFER_DEPTH];
    t_entry             r_rd_data;
    t_back_state        r_state;
    t_back_state        n_state;
    t_flush_cmd         r_cmd;
    logic [CNT_W-1:0]   r_idx;
    logic               r_out_valid;
    logic [DATA_W-1:0]  r_out_data;
    logic               r_out_last;

    logic               out_free;
    logic               more;
    logic               load_entry;
    logic               load_last;
    logic [ADDR_W-1:0]  rd_addr;

    assign out_free = !r_out_valid || i_m_tready;
    assign more     = (r_idx < r_cmd.count);
    assign rd_addr  = more ? r_idx[ADDR_W-1:0] : '0;

    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE: begin
                if (i_q_valid) begin
                    n_state = BK_FETCH;
                end
            end
            BK_FETCH: begin
                if (more) begin
                    n_state = BK_LOAD;
                end else if (out_free) begin
                    n_state = BK_IDLE;
                end
            end
            BK_LOAD: begin
                if (out_free) begin
                    n_state = BK_FETCH;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    always_comb begin
        o_q_pop    = 1'b0;
        load_entry = 1'b0;
        load_last  = 1'b0;
        case (r_state)
            BK_IDLE:  o_q_pop    = i_q_valid;
            BK_FETCH: load_last  = !more && out_free;
            BK_LOAD:  load_entry = out_free;
            default: begin
            end
        endcase
    end

    assign o_flush_done = load_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_q_pop) begin
                r_idx <= '0;
            end else if (load_entry) begin
                r_idx <= r_idx + 1'b1;
            end
            if (load_entry || load_last) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_cmd <= i_q_cmd;
        end
        if (load_entry) begin
            r_out_data <= DATA_W'({r_rd_data.tag, r_rd_data.payload,
                                   r_rd_data.ev_time, r_cmd.state});
            r_out_last <= 1'b0;
        end else if (load_last) begin
            r_out_data <= DATA_W'({r_cmd.cur.tag, r_cmd.cur.payload,
                                   r_cmd.cur.ev_time, r_cmd.state});
            r_out_last <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_mem_wr.en) begin
            r_mem[i_mem_wr.addr] <= i_mem_wr.data;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tlast  = r_out_last;

endmodule

`default_nettype wire

### hdl/ssg_checker.sv
// ----------------------------------------------------------------------------
// ssg_checker
// Port-level checks of the stable state event gate, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module ssg_checker import ssg_pkg::*; (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              s_axis_tvalid,
    input wire logic              s_axis_tready,
    input wire logic              m_axis_tvalid,
    input wire logic              m_axis_tready,
    input wire logic [DATA_W-1:0] m_axis_tdata,
    input wire logic              m_axis_tlast
);

    logic               out_acc;
    logic               in_acc;
    logic               r_open;
    logic [STATE_W-1:0] r_open_state;

    assign out_acc = m_axis_tvalid && m_axis_tready;
    assign in_acc  = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= 1'b0;
        end else if (out_acc) begin
            r_open <= !m_axis_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_acc) begin
            r_open_state <= m_axis_tdata[STATE_W-1:0];
        end
    end

    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "output word withdrawn while stalled")
    `ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata) && $stable(m_axis_tlast), "stalled output word changed")
    `ASSERT_IMPLY(a_run_blocks_input, i_clk, i_rst_n, out_acc && !m_axis_tlast, !in_acc, "input taken while a release is still being sent")
    `ASSERT_IMPLY(a_run_same_state, i_clk, i_rst_n, out_acc && r_open, m_axis_tdata[STATE_W-1:0] == r_open_state, "state code changed within one release")

endmodule

bind stable_state_event_gate ssg_checker u_ssg_checker (.*);

`default_nettype wire
